[sv/hsvrgb_pkg.sv]
// ============================================================================
// hsvrgb_pkg
// Shared types and fixed-point constants for the HSV to RGB converter.
// ============================================================================
`default_nettype none

package hsvrgb_pkg;

    // Hue angle scale: 1/16 degree, one turn and one 60-degree sector
    localparam int unsigned HUE_W      = 15;
    localparam int unsigned HWRAP_W    = 13;   // wrapped hue, 0..5759
    localparam int unsigned REM_W      = 10;   // remainder in sector, 0..959
    localparam int signed   HUE_LOW    = -5760;
    localparam int signed   HUE_HIGH   = 11519;
    localparam int signed   HUE_TURN   = 5760;
    localparam int unsigned HUE_SECTOR = 960;

    // Channel width
    localparam int unsigned CH_W = 8;

    // floor(rem * 256 / 960) = floor(rem * 4 / 15) = (rem * 17480) >> 16 for rem < 960
    localparam int unsigned FRAC_RECIP = 17480;
    localparam int unsigned FRAC_SHIFT = 16;

    // floor(n / 255) = (n * 32897) >> 23 for n <= 65152
    localparam int unsigned DIV255_RECIP = 32897;
    localparam int unsigned DIV255_SHIFT = 23;

    // 255 * 256 and rounding offsets
    localparam int unsigned FRAC_DEN   = 65280;
    localparam int unsigned P_ROUND    = 127;
    localparam int unsigned QT_ROUND   = 32640;

    // 60-degree sector of the wrapped hue
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // Side data that travels along the pipeline with each request
    typedef struct packed {
        t_sector          sector;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_side;

    // Start of a sector in hue units
    function automatic logic [HWRAP_W-1:0] sector_base(input t_sector sec);
        logic [HWRAP_W-1:0] base;
        case (sec)
            SEC_0:   base = HWRAP_W'(0);
            SEC_1:   base = HWRAP_W'(HUE_SECTOR);
            SEC_2:   base = HWRAP_W'(2 * HUE_SECTOR);
            SEC_3:   base = HWRAP_W'(3 * HUE_SECTOR);
            SEC_4:   base = HWRAP_W'(4 * HUE_SECTOR);
            SEC_5:   base = HWRAP_W'(5 * HUE_SECTOR);
            default: base = HWRAP_W'(0);
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

[sv/hsvrgb_div255.sv]
// ============================================================================
// hsvrgb_div255
// Registered reciprocal-multiply divide by 255, one result per enabled cycle.
// ============================================================================
`default_nettype none

module hsvrgb_div255 (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [15:0]               i_num,   // dividend, at most 65152
    output logic [hsvrgb_pkg::CH_W-1:0]    o_quo
);
    import hsvrgb_pkg::*;

    localparam int unsigned PROD_W = 32;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    // Reciprocal product; quotient is taken from the top bits
    assign n_prod = PROD_W'(i_num) * PROD_W'(DIV255_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_quo = r_prod[DIV255_SHIFT +: CH_W];

endmodule

`default_nettype wire

[sv/hsv_to_rgb_converter.sv]
// ============================================================================
// hsv_to_rgb_converter
// Fixed-point HSV to RGB stream conversion, one pixel per clock unless stalled.
// ============================================================================
// Accepts one color per clock while the input is ready and returns it as red,
// green and blue through a seven-stage pipeline: hue clamp and wrap, sector
// split, sector fraction, p/q/t products, numerators, reciprocal divides by
// 255, and the output register with sector routing. Every stage holds its
// own valid bit and moves on its own, so a stall on the output fills empty
// stages first and the input stays ready while any stage is free. Hue is in
// 1/16 degree, saturation and value are 8-bit fractions (255 = 1.0); zero
// saturation gives grey at the input value.
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input requests
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // hue[14:0], saturation[22:15],
                                               // brightness[30:23], zero[31]
    // Output requests
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsvrgb_pkg::*;

    localparam int unsigned NSTG   = 7;
    localparam int unsigned FPROD_W = 25;
    localparam int unsigned NUM_W  = 24;

    // ---------------------------------------------------------------------
    // Stage flow control
    // ---------------------------------------------------------------------
    logic [NSTG:1]   r_vld;
    logic [NSTG:1]   n_vld;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = i_m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[1] = i_s_axis_tvalid;
        for (int k = 2; k <= NSTG; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_axis_tready = en[1];
    assign o_m_axis_tvalid = r_vld[NSTG];

    // ---------------------------------------------------------------------
    // Stage 1: clamp hue to range and wrap into one turn
    // ---------------------------------------------------------------------
    logic signed [HUE_W:0]   hue_ext;
    logic signed [HUE_W:0]   hue_clamp;
    logic signed [HUE_W:0]   hue_wrap;
    logic [HWRAP_W-1:0]      r1_h;
    logic [CH_W-1:0]         r1_s;
    logic [CH_W-1:0]         r1_v;

    always_comb begin
        hue_ext = {i_s_axis_tdata[HUE_W-1], i_s_axis_tdata[HUE_W-1:0]};
        if (hue_ext < (HUE_W+1)'(HUE_LOW)) begin
            hue_clamp = (HUE_W+1)'(HUE_LOW);
        end else if (hue_ext > (HUE_W+1)'(HUE_HIGH)) begin
            hue_clamp = (HUE_W+1)'(HUE_HIGH);
        end else begin
            hue_clamp = hue_ext;
        end
        if (hue_clamp < 0) begin
            hue_wrap = hue_clamp + (HUE_W+1)'(HUE_TURN);
        end else if (hue_clamp >= (HUE_W+1)'(HUE_TURN)) begin
            hue_wrap = hue_clamp - (HUE_W+1)'(HUE_TURN);
        end else begin
            hue_wrap = hue_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_h <= hue_wrap[HWRAP_W-1:0];
            r1_s <= i_s_axis_tdata[HUE_W +: CH_W];
            r1_v <= i_s_axis_tdata[HUE_W+CH_W +: CH_W];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: sector and remainder within the sector
    // ---------------------------------------------------------------------
    t_sector            sec;
    logic [HWRAP_W-1:0] rem_full;
    t_side              r2_side;
    logic [REM_W-1:0]   r2_rem;

    always_comb begin
        if (r1_h >= sector_base(SEC_5)) begin
            sec = SEC_5;
        end else if (r1_h >= sector_base(SEC_4)) begin
            sec = SEC_4;
        end else if (r1_h >= sector_base(SEC_3)) begin
            sec = SEC_3;
        end else if (r1_h >= sector_base(SEC_2)) begin
            sec = SEC_2;
        end else if (r1_h >= sector_base(SEC_1)) begin
            sec = SEC_1;
        end else begin
            sec = SEC_0;
        end
        rem_full = r1_h - sector_base(sec);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_side <= '{sector: sec, sat: r1_s, val: r1_v};
            r2_rem  <= rem_full[REM_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: 8-bit fraction, rem * 256 / 960 by reciprocal
    // ---------------------------------------------------------------------
    logic [FPROD_W-1:0] f_prod;
    t_side              r3_side;
    logic [CH_W-1:0]    r3_f;

    assign f_prod = FPROD_W'(r2_rem) * FPROD_W'(FRAC_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_side <= r2_side;
            r3_f    <= f_prod[FRAC_SHIFT +: CH_W];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: S*f, S*(256-f) and the p numerator
    // ---------------------------------------------------------------------
    t_side       r4_side;
    logic [15:0] r4_sf;
    logic [15:0] r4_sfc;
    logic [15:0] r4_pn;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_side <= r3_side;
            r4_sf   <= 16'(r3_side.sat) * 16'(r3_f);
            r4_sfc  <= 16'(r3_side.sat) * (16'd256 - 16'(r3_f));
            r4_pn   <= 16'(r3_side.val) * 16'(8'd255 - r3_side.sat) + 16'(P_ROUND);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: q and t numerators; p divide starts
    // ---------------------------------------------------------------------
    t_side           r5_side;
    logic [NUM_W-1:0] r5_qn;
    logic [NUM_W-1:0] r5_tn;
    logic [CH_W-1:0]  p_quo;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_side <= r4_side;
            r5_qn   <= NUM_W'(r4_side.val) * (NUM_W'(FRAC_DEN) - NUM_W'(r4_sf))
                       + NUM_W'(QT_ROUND);
            r5_tn   <= NUM_W'(r4_side.val) * (NUM_W'(FRAC_DEN) - NUM_W'(r4_sfc))
                       + NUM_W'(QT_ROUND);
        end
    end

    hsvrgb_div255 u_div_p (
        .i_clk (i_clk),
        .i_en  (en[5]),
        .i_num (r4_pn),
        .o_quo (p_quo)
    );

    // ---------------------------------------------------------------------
    // Stage 6: q and t divides (n / 65280 = (n >> 8) / 255); p settles
    // ---------------------------------------------------------------------
    t_side           r6_side;
    logic [CH_W-1:0] r6_p;
    logic [CH_W-1:0] q_quo;
    logic [CH_W-1:0] t_quo;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_side <= r5_side;
            r6_p    <= p_quo;
        end
    end

    hsvrgb_div255 u_div_q (
        .i_clk (i_clk),
        .i_en  (en[6]),
        .i_num (r5_qn[NUM_W-1:CH_W]),
        .o_quo (q_quo)
    );

    hsvrgb_div255 u_div_t (
        .i_clk (i_clk),
        .i_en  (en[6]),
        .i_num (r5_tn[NUM_W-1:CH_W]),
        .o_quo (t_quo)
    );

    // ---------------------------------------------------------------------
    // Stage 7: route p, q, t and V by sector into the output register
    // ---------------------------------------------------------------------
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;

    always_comb begin
        case (r6_side.sector)
            SEC_0: begin
                n_red = r6_side.val; n_green = t_quo;       n_blue = r6_p;
            end
            SEC_1: begin
                n_red = q_quo;       n_green = r6_side.val; n_blue = r6_p;
            end
            SEC_2: begin
                n_red = r6_p;        n_green = r6_side.val; n_blue = t_quo;
            end
            SEC_3: begin
                n_red = r6_p;        n_green = q_quo;       n_blue = r6_side.val;
            end
            SEC_4: begin
                n_red = t_quo;       n_green = r6_p;        n_blue = r6_side.val;
            end
            default: begin
                n_red = r6_side.val; n_green = r6_p;        n_blue = q_quo;
            end
        endcase
        // grey when saturation is zero
        if (r6_side.sat == '0) begin
            n_red   = r6_side.val;
            n_green = r6_side.val;
            n_blue  = r6_side.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_m_axis_tdata = {r_blue, r_green, r_red};

endmodule

`default_nettype wire

[sv/hsvrgb_checker.sv]
// ============================================================================
// hsvrgb_checker
// Port-level checks on the converter's stream handshakes, bound to the top.
// ============================================================================
`default_nettype none

module hsvrgb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Empty output stage means the pipeline has room for a new request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input not ready with empty output stage");

    // Downstream taking data means every stage can advance
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input not ready while output drains");

    // First request after reset needs all seven stages before it shows
    a_min_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |-> !o_m_axis_tvalid [*7])
        else $error("output valid sooner than the pipeline depth after reset");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
